// ----- src/scm_pkg.sv -----
// Shared types and constants for the sphere contact manifold block.
// No dependencies; imported by every module of the block.
package scm_pkg;

   // Pair kind codes
   localparam logic [1:0] KIND_SPH_SPH = 2'd0;
   localparam logic [1:0] KIND_SPH_BOX = 2'd1;
   localparam logic [1:0] KIND_BOX_SPH = 2'd2;
   localparam logic [1:0] KIND_BOX_BOX = 2'd3;

   // Difference component magnitude: up to 2^33
   localparam int DIFF_W = 34;
   // Sum of three squares: below 2^68
   localparam int SUMSQ_W = 68;
   // Contact radius: up to 2^32
   localparam int RAD_W = 33;
   // Integer square root of the sum of squares: up to 36 bits
   localparam int ROOT_W = 36;
   // Dividend for one normal component: magnitude shifted up by 15
   localparam int NUM_W = DIFF_W + 15;
   // Normal quotient width before saturation
   localparam int QUO_W = 16;
   localparam logic [QUO_W-1:0] NORM_MAX = 16'd32767;

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;

   // Classified pair, handed from the front to the back
   typedef struct packed {
      logic                 valid_kind;
      logic [15:0]          first_id;
      logic [15:0]          second_id;
      logic [RAD_W-1:0]     rad;
      logic [2:0]           neg;
      logic [DIFF_W-1:0]    mag_x;
      logic [DIFF_W-1:0]    mag_y;
      logic [DIFF_W-1:0]    mag_z;
   } pair_type;

   // Finished contact result
   typedef struct packed {
      logic                 hit;
      logic [15:0]          first_id;
      logic [15:0]          second_id;
      logic [31:0]          penetration;
      logic [15:0]          normal_x;
      logic [15:0]          normal_y;
      logic [15:0]          normal_z;
      logic                 degenerate;
   } result_type;

   // Fixed-position signed clamp of a 34-bit value into [lo, hi]
   function automatic logic signed [DIFF_W-1:0] clamp34(
      input logic signed [DIFF_W-1:0] v,
      input logic signed [DIFF_W-1:0] lo,
      input logic signed [DIFF_W-1:0] hi);
      logic signed [DIFF_W-1:0] r;
      begin
         if (v < lo) r = lo;
         else if (v > hi) r = hi;
         else r = v;
         return r;
      end
   endfunction

endpackage

// ----- src/scm_fifo.sv -----
// Short pair queue between the front classifier and the back pipeline.
// Depends on scm_pkg for the pair type and depth.
module scm_fifo
   import scm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  pair_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output pair_type rd_data,
   output logic     empty
);

   pair_type              mem [QDEPTH];
   logic [QPTR_W-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [QPTR_W:0]       cnt_ff, cnt_in;
   logic                  do_wr, do_rd;

   assign full    = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem[rp_ff];

   // pointer and count update
   always_comb begin
      wp_in  = do_wr ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_rd ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) mem[wp_ff] <= wr_data;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_W+1)'(QDEPTH))
      else $error("queue count overflow");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (QPTR_W'(wp_ff - rp_ff) == cnt_ff[QPTR_W-1:0]))
      else $error("queue pointers disagree with count");
   a_empty_full: assert property (@(posedge clock) disable iff (reset)
      !(empty && full))
      else $error("queue both empty and full");
`endif

endmodule

// ----- src/scm_front.sv -----
// Front: accepts a pair, swaps roles for box-sphere, clamps and forms differences.
// Depends on scm_pkg.
module scm_front
   import scm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [1:0]         kind,
   input  logic signed [31:0] pos_a_x,
   input  logic signed [31:0] pos_a_y,
   input  logic signed [31:0] pos_a_z,
   input  logic signed [31:0] pos_b_x,
   input  logic signed [31:0] pos_b_y,
   input  logic signed [31:0] pos_b_z,
   input  logic [30:0]        radius,
   input  logic [30:0]        extent_x,
   input  logic [30:0]        extent_y,
   input  logic [30:0]        extent_z,
   input  logic [31:0]        id_pair,
   output logic               out_valid,
   input  logic               out_ready,
   output pair_type           out_pair
);

   logic                     vld_ff;
   pair_type                 pair_ff, pair_in;
   logic signed [DIFF_W-1:0] sc [3], bc [3], dd [3];
   logic signed [DIFF_W-1:0] ex [3];

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_pair  = pair_ff;

   // classify and build difference vector
   always_comb begin
      ex[0] = DIFF_W'(extent_x);
      ex[1] = DIFF_W'(extent_y);
      ex[2] = DIFF_W'(extent_z);
      if (kind == KIND_BOX_SPH) begin
         sc[0] = DIFF_W'(pos_b_x); sc[1] = DIFF_W'(pos_b_y); sc[2] = DIFF_W'(pos_b_z);
         bc[0] = DIFF_W'(pos_a_x); bc[1] = DIFF_W'(pos_a_y); bc[2] = DIFF_W'(pos_a_z);
      end else begin
         sc[0] = DIFF_W'(pos_a_x); sc[1] = DIFF_W'(pos_a_y); sc[2] = DIFF_W'(pos_a_z);
         bc[0] = DIFF_W'(pos_b_x); bc[1] = DIFF_W'(pos_b_y); bc[2] = DIFF_W'(pos_b_z);
      end
      for (int i = 0; i < 3; i++) begin
         if (kind == KIND_SPH_SPH) dd[i] = bc[i] - sc[i];
         else dd[i] = clamp34(sc[i], bc[i] - ex[i], bc[i] + ex[i]) - sc[i];
      end
      pair_in.valid_kind = (kind != KIND_BOX_BOX);
      if (kind == KIND_BOX_SPH) begin
         pair_in.first_id  = id_pair[15:0];
         pair_in.second_id = id_pair[31:16];
      end else begin
         pair_in.first_id  = id_pair[31:16];
         pair_in.second_id = id_pair[15:0];
      end
      pair_in.rad = (kind == KIND_SPH_SPH) ? RAD_W'(radius) + RAD_W'(extent_x)
                                           : RAD_W'(radius);
      pair_in.neg   = {dd[2][DIFF_W-1], dd[1][DIFF_W-1], dd[0][DIFF_W-1]};
      pair_in.mag_x = dd[0][DIFF_W-1] ? -dd[0] : dd[0];
      pair_in.mag_y = dd[1][DIFF_W-1] ? -dd[1] : dd[1];
      pair_in.mag_z = dd[2][DIFF_W-1] ? -dd[2] : dd[2];
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (in_ready) vld_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) pair_ff <= pair_in;
   end

endmodule

// ----- src/scm_back.sv -----
// Back: squares, hit test, pipelined square root and three pipelined dividers.
// Depends on scm_pkg. Pipeline that stalls as a whole; output register at the end.
module scm_back
   import scm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  pair_type   in_pair,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_res
);

   // stage counts: squares 1, sum 1, hit compare 1, root ROOT_W, divide QUO_W, finish 1
   localparam int NSQ   = 3;
   localparam int NRT   = ROOT_W;
   localparam int NDV   = QUO_W;
   localparam int NST   = NSQ + NRT + NDV + 1;
   // trial value width for the root recurrence
   localparam int TRW   = 2*ROOT_W + 1;

   typedef struct packed {
      logic              valid_kind;
      logic [15:0]       first_id;
      logic [15:0]       second_id;
      logic [RAD_W-1:0]  rad;
      logic [2:0]        neg;
      logic [DIFF_W-1:0] mag_x;
      logic [DIFF_W-1:0] mag_y;
      logic [DIFF_W-1:0] mag_z;
      logic              hit;
   } ctx_type;

   logic                 adv;
   logic [NST-1:0]       vld_ff;
   ctx_type              ctx_ff [NST-1];
   // square stage products
   logic [2*DIFF_W-1:0]  sq_ff [3];
   logic [2*RAD_W-1:0]   rr_ff;
   logic [2*RAD_W-1:0]   rr2_ff;
   logic [SUMSQ_W-1:0]   sum_ff;
   // root pipeline: remainder and partial root
   logic [SUMSQ_W-1:0]   rs_ff [NRT+1];
   logic [ROOT_W-1:0]    rq_ff [NRT+1];
   // divider pipeline, three lanes; entry k holds the output of stage k
   logic [NUM_W-1:0]     dr_ff [NDV][3];
   logic [QUO_W-1:0]     dq_ff [NDV][3];
   logic [ROOT_W-1:0]    dd_ff [NDV];
   // divider stage inputs
   logic [ROOT_W-1:0]    dv_src [NDV];
   logic [NUM_W-1:0]     dr_src [NDV][3];
   logic [QUO_W-1:0]     dq_src [NDV][3];
   result_type           res_ff;

   assign adv       = !vld_ff[NST-1] || out_ready;
   assign in_ready  = adv;
   assign out_valid = vld_ff[NST-1];
   assign out_res   = res_ff;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NST-2:0], in_valid};
   end

   // divider inputs: first stage from the root output and context
   always_comb begin
      dv_src[0]    = rq_ff[NRT];
      dr_src[0][0] = NUM_W'(ctx_ff[NSQ+NRT-1].mag_x) << 15;
      dr_src[0][1] = NUM_W'(ctx_ff[NSQ+NRT-1].mag_y) << 15;
      dr_src[0][2] = NUM_W'(ctx_ff[NSQ+NRT-1].mag_z) << 15;
      for (int l = 0; l < 3; l++) dq_src[0][l] = '0;
      for (int k = 1; k < NDV; k++) begin
         dv_src[k] = dd_ff[k-1];
         for (int l = 0; l < 3; l++) begin
            dr_src[k][l] = dr_ff[k-1][l];
            dq_src[k][l] = dq_ff[k-1][l];
         end
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (adv) begin
         ctx_type          c2;
         ctx_type          c;
         logic [QUO_W-1:0] q [3];
         logic [15:0]      n [3];

         // stage 0: squares
         ctx_ff[0].valid_kind <= in_pair.valid_kind;
         ctx_ff[0].first_id   <= in_pair.first_id;
         ctx_ff[0].second_id  <= in_pair.second_id;
         ctx_ff[0].rad        <= in_pair.rad;
         ctx_ff[0].neg        <= in_pair.neg;
         ctx_ff[0].mag_x      <= in_pair.mag_x;
         ctx_ff[0].mag_y      <= in_pair.mag_y;
         ctx_ff[0].mag_z      <= in_pair.mag_z;
         ctx_ff[0].hit        <= 1'b0;
         sq_ff[0] <= in_pair.mag_x * in_pair.mag_x;
         sq_ff[1] <= in_pair.mag_y * in_pair.mag_y;
         sq_ff[2] <= in_pair.mag_z * in_pair.mag_z;
         rr_ff    <= in_pair.rad * in_pair.rad;

         // stage 1: sum of squares; stage 2: hit compare
         ctx_ff[1] <= ctx_ff[0];
         sum_ff <= SUMSQ_W'(sq_ff[0]) + SUMSQ_W'(sq_ff[1]) + SUMSQ_W'(sq_ff[2]);
         rr2_ff <= rr_ff;
         c2     = ctx_ff[1];
         c2.hit = ctx_ff[1].valid_kind && (sum_ff <= SUMSQ_W'(rr2_ff));
         ctx_ff[2] <= c2;
         rs_ff[0]  <= sum_ff;
         rq_ff[0]  <= '0;

         // square root, one result bit per stage, MSB first, on the remainder
         for (int k = 0; k < NRT; k++) begin
            logic [TRW-1:0] trial;
            trial = (TRW'(rq_ff[k]) << (NRT - k)) + (TRW'(1) << (2 * (NRT - 1 - k)));
            ctx_ff[NSQ+k] <= ctx_ff[NSQ+k-1];
            if (trial <= TRW'(rs_ff[k])) begin
               rs_ff[k+1] <= rs_ff[k] - SUMSQ_W'(trial);
               rq_ff[k+1] <= rq_ff[k] | (ROOT_W'(1) << (NRT - 1 - k));
            end else begin
               rs_ff[k+1] <= rs_ff[k];
               rq_ff[k+1] <= rq_ff[k];
            end
         end

         // restoring divide, one quotient bit per stage
         for (int k = 0; k < NDV; k++) begin
            ctx_ff[NSQ+NRT+k] <= ctx_ff[NSQ+NRT+k-1];
            dd_ff[k] <= dv_src[k];
            for (int l = 0; l < 3; l++) begin
               logic [NUM_W+ROOT_W-1:0] sub;
               sub = (NUM_W+ROOT_W)'(dv_src[k]) << (NDV - 1 - k);
               if ((NUM_W+ROOT_W)'(dr_src[k][l]) >= sub) begin
                  dr_ff[k][l] <= NUM_W'((NUM_W+ROOT_W)'(dr_src[k][l]) - sub);
                  dq_ff[k][l] <= dq_src[k][l] | (QUO_W'(1) << (NDV - 1 - k));
               end else begin
                  dr_ff[k][l] <= dr_src[k][l];
                  dq_ff[k][l] <= dq_src[k][l];
               end
            end
         end

         // final formatting; the divisor doubles as the distance
         c = ctx_ff[NST-2];
         for (int l = 0; l < 3; l++) begin
            q[l] = (dq_ff[NDV-1][l] > NORM_MAX) ? NORM_MAX : dq_ff[NDV-1][l];
            n[l] = c.neg[l] ? -q[l] : q[l];
         end
         res_ff.first_id  <= c.first_id;
         res_ff.second_id <= c.second_id;
         res_ff.hit       <= c.hit;
         if (c.hit) begin
            res_ff.penetration <= 32'(c.rad - RAD_W'(dd_ff[NDV-1]));
            res_ff.degenerate  <= (dd_ff[NDV-1] == '0);
            if (dd_ff[NDV-1] == '0) begin
               res_ff.normal_x <= '0; res_ff.normal_y <= '0; res_ff.normal_z <= '0;
            end else begin
               res_ff.normal_x <= n[0]; res_ff.normal_y <= n[1]; res_ff.normal_z <= n[2];
            end
         end else begin
            res_ff.penetration <= '0;
            res_ff.degenerate  <= 1'b0;
            res_ff.normal_x <= '0; res_ff.normal_y <= '0; res_ff.normal_z <= '0;
         end
      end
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(res_ff)))
      else $error("result changed while stalled");
   a_degen_hit: assert property (@(posedge clock) disable iff (reset)
      (out_valid && res_ff.degenerate) |-> res_ff.hit)
      else $error("degenerate without hit");
   a_nohit_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !res_ff.hit) |-> (res_ff.penetration == '0))
      else $error("penetration on a miss");
`endif

endmodule

// ----- src/sphere_contact_manifold_top.sv -----
// Sphere contact manifold: narrow-phase contact test, one result per pair.
// Path from the accepting edge to a valid result: front register, queue write,
// then 56 back pipeline stages; every stage holds while a result waits for pop.
// Throughput: one pair per cycle while pop keeps up, set by the fully pipelined
// 36-step square root and three 16-step restoring dividers in the back pipeline.
// Reset: synchronous, active high; clears all valid flags and queue pointers.
module sphere_contact_manifold_top
   import scm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_pos_a_x,
   input  logic signed [31:0] req_pos_a_y,
   input  logic signed [31:0] req_pos_a_z,
   input  logic signed [31:0] req_pos_b_x,
   input  logic signed [31:0] req_pos_b_y,
   input  logic signed [31:0] req_pos_b_z,
   input  logic [30:0]        req_radius,
   input  logic [30:0]        req_extent_x,
   input  logic [30:0]        req_extent_y,
   input  logic [30:0]        req_extent_z,
   input  logic [31:0]        req_id_pair,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_hit,
   output logic [15:0]        rsp_first_id,
   output logic [15:0]        rsp_second_id,
   output logic [31:0]        rsp_penetration,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic               rsp_degenerate
);

   logic       fr_valid, fr_ready, q_full, q_empty, bk_ready, bk_valid;
   pair_type   fr_pair, q_pair;
   result_type res;
   logic       in_ready;

   assign full = !in_ready;

   scm_front u_front (
      .clock, .reset,
      .in_valid (push), .in_ready (in_ready),
      .kind (req_kind),
      .pos_a_x (req_pos_a_x), .pos_a_y (req_pos_a_y), .pos_a_z (req_pos_a_z),
      .pos_b_x (req_pos_b_x), .pos_b_y (req_pos_b_y), .pos_b_z (req_pos_b_z),
      .radius (req_radius),
      .extent_x (req_extent_x), .extent_y (req_extent_y), .extent_z (req_extent_z),
      .id_pair (req_id_pair),
      .out_valid (fr_valid), .out_ready (fr_ready), .out_pair (fr_pair)
   );

   assign fr_ready = !q_full;

   scm_fifo u_fifo (
      .clock, .reset,
      .wr_en (fr_valid), .wr_data (fr_pair), .full (q_full),
      .rd_en (bk_ready), .rd_data (q_pair), .empty (q_empty)
   );

   scm_back u_back (
      .clock, .reset,
      .in_valid (!q_empty), .in_ready (bk_ready), .in_pair (q_pair),
      .out_valid (bk_valid), .out_ready (pop), .out_res (res)
   );

   // result ports
   assign empty           = !bk_valid;
   assign rsp_hit         = res.hit;
   assign rsp_first_id    = res.first_id;
   assign rsp_second_id   = res.second_id;
   assign rsp_penetration = res.penetration;
   assign rsp_normal_x    = res.normal_x;
   assign rsp_normal_y    = res.normal_y;
   assign rsp_normal_z    = res.normal_z;
   assign rsp_degenerate  = res.degenerate;

endmodule

// ----- tb/sv/sphere_contact_manifold_top_test.sv -----
// Testbench for sphere_contact_manifold_top: directed and random pairs through
// the push/pop queue ports, each result checked against an in-bench predictor.
// Depends on scm_pkg for the pair kind codes.
module sphere_contact_manifold_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import scm_pkg::*;

   typedef struct {
      logic [1:0]         kind;
      logic signed [31:0] ax, ay, az, bx, by, bz;
      logic [30:0]        rad, ex, ey, ez;
      logic [31:0]        ids;
   } pair_t;

   typedef struct {
      logic        hit;
      logic [15:0] fid, sid;
      logic [31:0] pen;
      logic [15:0] nx, ny, nz;
      logic        degen;
   } contact_t;

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic pop = 0;
   logic full, empty;
   pair_t drive_pair = '{default: 0};

   logic        rsp_hit, rsp_degenerate;
   logic [15:0] rsp_first_id, rsp_second_id;
   logic [31:0] rsp_penetration;
   logic signed [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;

   pair_t    pending_pairs[$];
   contact_t expected_contacts[$];
   int       mismatches = 0;
   int       drv_cyc = 0;
   int       mon_cyc = 0;

   sphere_contact_manifold_top dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_kind(drive_pair.kind),
      .req_pos_a_x(drive_pair.ax), .req_pos_a_y(drive_pair.ay),
      .req_pos_a_z(drive_pair.az),
      .req_pos_b_x(drive_pair.bx), .req_pos_b_y(drive_pair.by),
      .req_pos_b_z(drive_pair.bz),
      .req_radius(drive_pair.rad), .req_extent_x(drive_pair.ex),
      .req_extent_y(drive_pair.ey), .req_extent_z(drive_pair.ez),
      .req_id_pair(drive_pair.ids),
      .empty(empty), .pop(pop),
      .rsp_hit(rsp_hit), .rsp_first_id(rsp_first_id), .rsp_second_id(rsp_second_id),
      .rsp_penetration(rsp_penetration), .rsp_normal_x(rsp_normal_x),
      .rsp_normal_y(rsp_normal_y), .rsp_normal_z(rsp_normal_z),
      .rsp_degenerate(rsp_degenerate)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // One normal component in Q1.15, truncated toward zero and saturated
   function automatic logic [15:0] unit_comp(longint v, logic [63:0] span);
      logic [63:0] m, q;
      m = (v < 0) ? 64'(-v) : 64'(v);
      q = (m << 15) / span;
      if (q > 64'd32767) q = 64'd32767;
      return (v < 0) ? 16'(-q) : 16'(q);
   endfunction

   // Contact prediction for one pair
   function automatic contact_t predict_contact(pair_t p);
      longint pa[3], pb[3], ext[3], diff[3], lo, hi, v;
      logic [63:0] m, r, root, t;
      logic [71:0] s;
      contact_t c;
      pa[0] = p.ax; pa[1] = p.ay; pa[2] = p.az;
      pb[0] = p.bx; pb[1] = p.by; pb[2] = p.bz;
      ext[0] = longint'({1'b0, p.ex}); ext[1] = longint'({1'b0, p.ey});
      ext[2] = longint'({1'b0, p.ez});
      c = '{default: 0};
      c.fid = p.ids[31:16];
      c.sid = p.ids[15:0];
      r = 64'(p.rad);
      if (p.kind == KIND_BOX_BOX) return c;
      for (int i = 0; i < 3; i++) begin
         if (p.kind == KIND_SPH_SPH) begin
            diff[i] = pb[i] - pa[i];
         end else begin
            if (p.kind == KIND_SPH_BOX) begin
               v = pa[i]; lo = pb[i] - ext[i]; hi = pb[i] + ext[i];
            end else begin
               v = pb[i]; lo = pa[i] - ext[i]; hi = pa[i] + ext[i];
            end
            diff[i] = ((v < lo) ? lo : ((v > hi) ? hi : v)) - v;
         end
      end
      if (p.kind == KIND_SPH_SPH) r = 64'(p.rad) + 64'(p.ex);
      if (p.kind == KIND_BOX_SPH) begin
         c.fid = p.ids[15:0];
         c.sid = p.ids[31:16];
      end
      s = 0;
      for (int i = 0; i < 3; i++) begin
         m = (diff[i] < 0) ? 64'(-diff[i]) : 64'(diff[i]);
         s = s + 72'(m) * 72'(m);
      end
      if (s > 72'(r) * 72'(r)) return c;
      // bitwise integer square root, floor
      root = 0;
      for (int b = 35; b >= 0; b--) begin
         t = root | (64'd1 << b);
         if (72'(t) * 72'(t) <= s) root = t;
      end
      c.hit = 1;
      c.pen = 32'(r - root);
      if (root == 0) begin
         c.degen = 1;
         return c;
      end
      c.nx = unit_comp(diff[0], root);
      c.ny = unit_comp(diff[1], root);
      c.nz = unit_comp(diff[2], root);
      return c;
   endfunction

   function automatic logic [30:0] rand31();
      return 31'($urandom);
   endfunction

   // Pair with random content, mostly close enough to touch
   function automatic pair_t random_pair();
      pair_t p;
      int k;
      logic [31:0] off_mask;
      p.kind = 2'($urandom_range(3));
      p.ids = $urandom;
      if ($urandom_range(99) < 25) begin
         p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
         p.bx = $urandom; p.by = $urandom; p.bz = $urandom;
         p.rad = rand31(); p.ex = rand31(); p.ey = rand31(); p.ez = rand31();
      end else begin
         if ($urandom_range(9) == 0) p.kind = 2'($urandom_range(2));
         k = $urandom_range(28);
         off_mask = (32'd1 << k) - 1;
         p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
         p.bx = p.ax + ($signed($urandom & off_mask) - $signed(off_mask >> 1));
         p.by = p.ay + ($signed($urandom & off_mask) - $signed(off_mask >> 1));
         p.bz = p.az + ($signed($urandom & off_mask) - $signed(off_mask >> 1));
         p.rad = 31'($urandom & off_mask);
         p.ex = 31'($urandom & (off_mask >> 1));
         p.ey = 31'($urandom & (off_mask >> 1));
         p.ez = 31'($urandom & (off_mask >> 1));
         if ($urandom_range(9) == 0) begin
            p.bx = p.ax; p.by = p.ay; p.bz = p.az;
         end
      end
      return p;
   endfunction

   function automatic pair_t make_pair(logic [1:0] kind, int ax, int ay, int az,
                                       int bx, int by, int bz, logic [30:0] rad,
                                       logic [30:0] ex, logic [30:0] ey,
                                       logic [30:0] ez, logic [31:0] ids);
      pair_t p;
      p.kind = kind; p.ax = ax; p.ay = ay; p.az = az;
      p.bx = bx; p.by = by; p.bz = bz;
      p.rad = rad; p.ex = ex; p.ey = ey; p.ez = ez; p.ids = ids;
      return p;
   endfunction

   // Stimulus and end of run
   initial begin
      localparam logic [30:0] RMAX = 31'h7FFF_FFFF;
      // touching spheres along x: normal saturates at one
      pending_pairs.push_back(make_pair(KIND_SPH_SPH, 0, 0, 0, 32'h0002_0000, 0, 0,
                                        31'h0001_0000, 31'h0001_0000, 0, 0, 32'h0001_0002));
      // separated spheres, no hit
      pending_pairs.push_back(make_pair(KIND_SPH_SPH, 0, 0, 0, 0, 32'h0003_0000, 0,
                                        31'h0001_0000, 31'h0001_0000, 0, 0, 32'hFFFF_0000));
      // coincident centers, degenerate
      pending_pairs.push_back(make_pair(KIND_SPH_SPH, 5, 5, 5, 5, 5, 5,
                                        0, 0, 0, 0, 32'h1234_5678));
      // extreme positions and radii
      pending_pairs.push_back(make_pair(KIND_SPH_SPH, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, RMAX, RMAX, RMAX, RMAX, 32'hFFFF_FFFF));
      pending_pairs.push_back(make_pair(KIND_SPH_SPH, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000,
                                        0, 0, RMAX, RMAX, 0, 0, 32'h0000_FFFF));
      pending_pairs.push_back(make_pair(KIND_SPH_SPH, 0, 0, 0, -32'sd7, 0, 0,
                                        31'd7, 0, 0, 0, 32'h0102_0304));
      // sphere-box: inside box, near face, far away, extremes
      pending_pairs.push_back(make_pair(KIND_SPH_BOX, 0, 0, 0, 0, 0, 0,
                                        31'h0001_0000, 31'h0002_0000, 31'h0002_0000,
                                        31'h0002_0000, 32'hAAAA_5555));
      pending_pairs.push_back(make_pair(KIND_SPH_BOX, 0, 0, 32'h0003_0000, 0, 0, 0,
                                        31'h0001_8000, 31'h0002_0000, 31'h0002_0000,
                                        31'h0002_0000, 32'h0007_0008));
      pending_pairs.push_back(make_pair(KIND_SPH_BOX, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, RMAX, RMAX, RMAX, RMAX, 32'h5555_AAAA));
      pending_pairs.push_back(make_pair(KIND_SPH_BOX, 32'h0010_0000, 32'h0010_0000, 0,
                                        0, 0, 0, 31'h0001_0000, 31'h0001_0000,
                                        31'h0001_0000, 31'h0001_0000, 32'h0011_0022));
      pending_pairs.push_back(make_pair(KIND_SPH_BOX, 3, -4, 0, 0, 0, 0,
                                        31'd5, 0, 0, 0, 32'h0033_0044));
      // box-sphere: ids swapped
      pending_pairs.push_back(make_pair(KIND_BOX_SPH, 0, 0, 0, 32'h0003_0000, 0, 0,
                                        31'h0001_8000, 31'h0002_0000, 31'h0002_0000,
                                        31'h0002_0000, 32'hBEEF_0001));
      pending_pairs.push_back(make_pair(KIND_BOX_SPH, 0, 0, 0, 1, 1, 1,
                                        31'd1, 31'd4, 31'd4, 31'd4, 32'h0001_BEEF));
      pending_pairs.push_back(make_pair(KIND_BOX_SPH, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, RMAX, 0, 0, 0, 32'hFFFF_FFFF));
      pending_pairs.push_back(make_pair(KIND_BOX_SPH, 0, 0, 0, 0, 0, 32'h0100_0000,
                                        31'd3, 31'd1, 31'd1, 31'd1, 32'h0000_0000));
      // unsupported box-box
      pending_pairs.push_back(make_pair(KIND_BOX_BOX, 0, 0, 0, 0, 0, 0,
                                        RMAX, RMAX, RMAX, RMAX, 32'hCAFE_F00D));
      for (int i = 0; i < 500; i++) pending_pairs.push_back(random_pair());

      repeat (4) @(posedge clock);
      reset <= 0;
      while (pending_pairs.size() != 0 || expected_contacts.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_contacts.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Driver: accept on push && !full, then offer the next pending pair
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         push <= 0;
      end else begin
         drv_cyc = drv_cyc + 1;
         if (push && !full) begin
            expected_contacts.push_back(predict_contact(pending_pairs[0]));
            void'(pending_pairs.pop_front());
         end
         offer = pending_pairs.size() != 0 &&
                 ((drv_cyc >= 1200 && drv_cyc < 2200) || $urandom_range(99) >= 25);
         push <= offer;
         if (offer) drive_pair <= pending_pairs[0];
      end
   end

   // Monitor: check each result transfer, then choose pop for the next edge
   always @(posedge clock) begin
      contact_t e;
      logic ok;
      if (reset) begin
         pop <= 0;
      end else begin
         mon_cyc = mon_cyc + 1;
         if (pop && !empty) begin
            if (expected_contacts.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
            end else begin
               e = expected_contacts.pop_front();
               ok = rsp_hit === e.hit && rsp_first_id === e.fid &&
                    rsp_second_id === e.sid && rsp_penetration === e.pen &&
                    rsp_normal_x === e.nx && rsp_normal_y === e.ny &&
                    rsp_normal_z === e.nz && rsp_degenerate === e.degen;
               if (!ok) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display({"mismatch at %0t: exp hit=%b ids=%h/%h pen=%h n=%h/%h/%h",
                               " dg=%b, got hit=%b ids=%h/%h pen=%h n=%h/%h/%h dg=%b"},
                              $realtime, e.hit, e.fid, e.sid, e.pen, e.nx, e.ny, e.nz,
                              e.degen, rsp_hit, rsp_first_id, rsp_second_id,
                              rsp_penetration, rsp_normal_x, rsp_normal_y,
                              rsp_normal_z, rsp_degenerate);
               end
            end
         end
         // long hold-off fills the block; an idle-free stretch follows later
         if (mon_cyc >= 600 && mon_cyc < 900) pop <= 0;
         else if (mon_cyc >= 1200 && mon_cyc < 2200) pop <= 1;
         else pop <= ($urandom_range(99) >= 25);
      end
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
